FILE: rtl/rmv_pkg.sv
// shared types and constants for the running mean / variance block
// no dependencies; used by rmv_alu and running_mean_variance_top
`default_nettype none

package rmv_pkg;

  // width of the sample counter; the count wraps at this width
  localparam int COUNT_BITS = 32;

  localparam int SAMPLE_W = 32;
  localparam int DMAG_W   = SAMPLE_W + 1;
  localparam int SQ_W     = 63;
  localparam int CNT_OUT_W = 32;
  localparam int SH_W     = SQ_W + 1;
  localparam int ADD_W    = (COUNT_BITS + 1 > DMAG_W + 1) ? COUNT_BITS + 1 : DMAG_W + 1;
  localparam int STEP_W   = $clog2(SH_W + 1);

  localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(DMAG_W);
  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(DMAG_W);
  localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(SQ_W);

  localparam logic [SQ_W-1:0] SQ_SAT = '1;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } rmv_op_t;

  typedef struct packed {
    logic                start;
    rmv_op_t             op;
    logic [STEP_W-1:0]   steps;
  } rmv_alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rmv_alu_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_MUL_ST,
    S_MUL,
    S_DIV2_ST,
    S_DIV2,
    S_OUT
  } rmv_state_t;

endpackage

`default_nettype wire

FILE: rtl/running_mean_variance_top.sv
// running mean and sample variance (online update), top level and sequencer
// depends on rmv_pkg and rmv_alu
`default_nettype none

// Takes one signed Q16.16 sample per item and returns one result item: the
// running mean (Q16.16), the sample variance sum/(count-1) as unsigned
// Q31.32 with saturation, a flag that is high once two or more samples are in,
// and the sample count. The divides and the multiply run through one shared
// unit that retires one bit per cycle: the mean step is a 33-step divide, the
// squared deviation a 33-step multiply and the variance a 63-step divide. The
// first sample of a run skips the variance divide, and an item that wraps the
// count to zero does not use the shared unit; it reports all zeros and the
// next sample starts a new run.
// in_ready is high only while no item is in work; a finished result sits in
// the output register, so the next item can be taken while the previous
// result waits. A result that still finds the output register occupied holds
// the block until that register is read.
module running_mean_variance_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_mean_value,
  output logic [62:0]              out_variance_value,
  output logic                     out_variance_valid,
  output logic [31:0]              out_sample_count
);

  localparam int CW = rmv_pkg::COUNT_BITS;
  localparam int SW = rmv_pkg::SAMPLE_W;
  localparam int DW = rmv_pkg::DMAG_W;
  localparam int QW = rmv_pkg::SQ_W;
  localparam int HW = rmv_pkg::SH_W;
  localparam int AW = rmv_pkg::ADD_W;

  rmv_pkg::rmv_state_t       state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [SW-1:0]      mean_r, mean_nxt;
  logic [QW-1:0]             sq_r, sq_nxt;
  logic signed [SW-1:0]      x_r, x_nxt;
  logic                      dneg_r, dneg_nxt;
  logic [DW-1:0]             dmag_r, dmag_nxt;
  logic [QW-1:0]             var_r, var_nxt;
  logic                      vok_r, vok_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]      out_mean_r, out_mean_nxt;
  logic [QW-1:0]             out_var_r, out_var_nxt;
  logic                      out_vok_r, out_vok_nxt;
  logic [rmv_pkg::CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  rmv_pkg::rmv_alu_cmd_t     alu_cmd;
  rmv_pkg::rmv_alu_sts_t     alu_sts;
  logic [HW-1:0]             alu_ld_sh;
  logic [AW-1:0]             alu_ld_opnd;
  logic [HW-1:0]             alu_sh;
  logic [AW-1:0]             alu_acc;

  logic                      fresh;
  logic [CW-1:0]             cnt_inc;
  logic signed [SW-1:0]      mean_base;
  logic signed [DW-1:0]      delta;
  logic [DW-1:0]             delta_mag;
  logic [DW-1:0]             quot;
  logic signed [DW-1:0]      mean_sum;
  logic signed [DW-1:0]      dev;
  logic [DW-1:0]             dev_mag;
  logic                      prod_sat;
  logic [QW-1:0]             prod;
  logic [QW:0]               sq_sum;
  logic                      out_load;

  rmv_alu u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (alu_cmd),
    .ld_sh_i   (alu_ld_sh),
    .ld_opnd_i (alu_ld_opnd),
    .sts_o     (alu_sts),
    .sh_o      (alu_sh),
    .acc_o     (alu_acc)
  );

  // datapath pieces around the shared unit
  always_comb begin
    fresh     = (count_r == '0);
    cnt_inc   = count_r + 1'b1;
    mean_base = fresh ? '0 : mean_r;
    delta     = {in_sample[SW-1], in_sample} - {mean_base[SW-1], mean_base};
    delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);

    quot      = alu_sh[DW-1:0];
    mean_sum  = {mean_r[SW-1], mean_r} + (dneg_r ? DW'(-quot) : quot);

    dev       = {x_r[SW-1], x_r} - {mean_r[SW-1], mean_r};
    dev_mag   = dev[DW-1] ? DW'(-dev) : DW'(dev);

    // full product is acc * 2^33 + sh[63:31]; saturate at 2^63 - 1
    prod_sat  = |alu_acc[AW-1:QW-DW];
    prod      = prod_sat ? rmv_pkg::SQ_SAT
                         : {alu_acc[QW-DW-1:0], alu_sh[HW-1:HW-DW]};
    sq_sum    = {1'b0, sq_r} + {1'b0, prod};
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    mean_nxt    = mean_r;
    sq_nxt      = sq_r;
    x_nxt       = x_r;
    dneg_nxt    = dneg_r;
    dmag_nxt    = dmag_r;
    var_nxt     = var_r;
    vok_nxt     = vok_r;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = rmv_pkg::OP_DIV;
    alu_cmd.steps = rmv_pkg::DIV1_STEPS;
    alu_ld_sh     = '0;
    alu_ld_opnd   = '0;
    out_load      = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      rmv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_inc == '0) begin
            // count wrapped: report zeros and restart the run
            count_nxt = '0;
            mean_nxt  = '0;
            sq_nxt    = '0;
            var_nxt   = '0;
            vok_nxt   = 1'b0;
            state_nxt = rmv_pkg::S_OUT;
          end else begin
            count_nxt = cnt_inc;
            mean_nxt  = mean_base;
            sq_nxt    = fresh ? '0 : sq_r;
            x_nxt     = in_sample;
            dneg_nxt  = delta[DW-1];
            dmag_nxt  = delta_mag;
            alu_cmd.start = 1'b1;
            alu_cmd.op    = rmv_pkg::OP_DIV;
            alu_cmd.steps = rmv_pkg::DIV1_STEPS;
            alu_ld_sh     = {delta_mag, (HW - DW)'(0)};
            alu_ld_opnd   = AW'(cnt_inc);
            state_nxt     = rmv_pkg::S_DIV1;
          end
        end
      end
      rmv_pkg::S_DIV1: begin
        if (alu_sts.done) begin
          mean_nxt  = mean_sum[SW-1:0];
          state_nxt = rmv_pkg::S_MUL_ST;
        end
      end
      rmv_pkg::S_MUL_ST: begin
        alu_cmd.start = 1'b1;
        alu_cmd.op    = rmv_pkg::OP_MUL;
        alu_cmd.steps = rmv_pkg::MUL_STEPS;
        alu_ld_sh     = HW'(dev_mag);
        alu_ld_opnd   = AW'(dmag_r);
        state_nxt     = rmv_pkg::S_MUL;
      end
      rmv_pkg::S_MUL: begin
        if (alu_sts.done) begin
          sq_nxt = sq_sum[QW] ? rmv_pkg::SQ_SAT : sq_sum[QW-1:0];
          if (|count_r[CW-1:1]) begin
            state_nxt = rmv_pkg::S_DIV2_ST;
          end else begin
            var_nxt   = '0;
            vok_nxt   = 1'b0;
            state_nxt = rmv_pkg::S_OUT;
          end
        end
      end
      rmv_pkg::S_DIV2_ST: begin
        alu_cmd.start = 1'b1;
        alu_cmd.op    = rmv_pkg::OP_DIV;
        alu_cmd.steps = rmv_pkg::DIV2_STEPS;
        alu_ld_sh     = {sq_r, (HW - QW)'(0)};
        alu_ld_opnd   = AW'(count_r - 1'b1);
        state_nxt     = rmv_pkg::S_DIV2;
      end
      rmv_pkg::S_DIV2: begin
        if (alu_sts.done) begin
          var_nxt   = alu_sh[QW-1:0];
          vok_nxt   = 1'b1;
          state_nxt = rmv_pkg::S_OUT;
        end
      end
      rmv_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = rmv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rmv_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_var_nxt   = out_var_r;
    out_vok_nxt   = out_vok_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mean_nxt  = mean_r;
      out_var_nxt   = var_r;
      out_vok_nxt   = vok_r;
      out_cnt_nxt   = rmv_pkg::CNT_OUT_W'(count_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmv_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_r     <= mean_nxt;
    sq_r       <= sq_nxt;
    x_r        <= x_nxt;
    dneg_r     <= dneg_nxt;
    dmag_r     <= dmag_nxt;
    var_r      <= var_nxt;
    vok_r      <= vok_nxt;
    out_mean_r <= out_mean_nxt;
    out_var_r  <= out_var_nxt;
    out_vok_r  <= out_vok_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mean_value     = out_mean_r;
  assign out_variance_value = out_var_r;
  assign out_variance_valid = out_vok_r;
  assign out_sample_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_var_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_variance_valid) |-> (out_variance_value == '0))
    else $error("variance nonzero while flagged invalid");

  a_alu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_cmd.start |-> !alu_sts.busy)
    else $error("shared unit started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == rmv_pkg::S_DIV1 || state_r == rmv_pkg::S_OUT))
    else $error("accepted item did not start work");

  a_out_alu_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmv_pkg::S_OUT) |-> !alu_sts.busy)
    else $error("shared unit still busy when result is ready");
`endif

endmodule

`default_nettype wire

FILE: rtl/rmv_alu.sv
// one-bit-per-cycle shared unit: restoring divide or shift-add multiply
// depends on rmv_pkg
`default_nettype none

module rmv_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rmv_pkg::rmv_alu_cmd_t      cmd_i,
  input  wire logic [rmv_pkg::SH_W-1:0]   ld_sh_i,
  input  wire logic [rmv_pkg::ADD_W-1:0]  ld_opnd_i,
  output rmv_pkg::rmv_alu_sts_t           sts_o,
  output logic [rmv_pkg::SH_W-1:0]        sh_o,
  output logic [rmv_pkg::ADD_W-1:0]       acc_o
);

  logic                          busy_r, busy_nxt;
  logic [rmv_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  rmv_pkg::rmv_op_t              op_r, op_nxt;
  logic [rmv_pkg::SH_W-1:0]      sh_r, sh_nxt;
  logic [rmv_pkg::ADD_W-1:0]     acc_r, acc_nxt;
  logic [rmv_pkg::ADD_W-1:0]     opnd_r, opnd_nxt;

  logic [rmv_pkg::ADD_W-1:0]     rem_sh;
  logic [rmv_pkg::ADD_W-1:0]     add_a;
  logic [rmv_pkg::ADD_W-1:0]     add_b;
  logic                          add_ci;
  logic [rmv_pkg::ADD_W:0]       sum;
  logic [rmv_pkg::ADD_W-1:0]     acc_step;
  logic [rmv_pkg::SH_W-1:0]      sh_step;

  // the single adder, shared by both operations
  always_comb begin
    rem_sh = {acc_r[rmv_pkg::ADD_W-2:0], sh_r[rmv_pkg::SH_W-1]};
    unique case (op_r)
      rmv_pkg::OP_DIV: begin
        add_a  = rem_sh;
        add_b  = ~opnd_r;
        add_ci = 1'b1;
      end
      rmv_pkg::OP_MUL: begin
        add_a  = acc_r;
        add_b  = sh_r[0] ? opnd_r : '0;
        add_ci = 1'b0;
      end
      default: begin
        add_a  = acc_r;
        add_b  = '0;
        add_ci = 1'b0;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + (rmv_pkg::ADD_W + 1)'(add_ci);

    unique case (op_r)
      rmv_pkg::OP_DIV: begin
        // carry out set means no borrow: quotient bit is one
        acc_step = sum[rmv_pkg::ADD_W] ? sum[rmv_pkg::ADD_W-1:0] : rem_sh;
        sh_step  = {sh_r[rmv_pkg::SH_W-2:0], sum[rmv_pkg::ADD_W]};
      end
      rmv_pkg::OP_MUL: begin
        acc_step = sum[rmv_pkg::ADD_W:1];
        sh_step  = {sum[0], sh_r[rmv_pkg::SH_W-1:1]};
      end
      default: begin
        acc_step = acc_r;
        sh_step  = sh_r;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    opnd_nxt = opnd_r;
    if (cmd_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd_i.steps;
      op_nxt   = cmd_i.op;
      sh_nxt   = ld_sh_i;
      acc_nxt  = '0;
      opnd_nxt = ld_opnd_i;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        sh_nxt  = sh_step;
        acc_nxt = acc_step;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    opnd_r <= opnd_nxt;
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = busy_r && (cnt_r == '0);
  assign sh_o       = sh_r;
  assign acc_o      = acc_r;

endmodule

`default_nettype wire
